// ----- src/thdt_pkg.sv -----
// Package: shared constants and register index codes for the two-hand IR dot tracker.
package thdt_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int NUM_DOTS       = 4;
  localparam int CFG_IDX_BITS   = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CHANGE_RADIUS = 3'd0,
    REG_MERGE_RADIUS  = 3'd1,
    REG_LEFT_START_X  = 3'd2,
    REG_LEFT_START_Y  = 3'd3,
    REG_RIGHT_START_X = 3'd4,
    REG_RIGHT_START_Y = 3'd5
  } cfg_reg_t;

endpackage

// ----- src/thdt_frame_if.sv -----
// Interface: one camera frame of four IR dots with valid/ready handshake.
interface thdt_frame_if #(
  parameter int COORD_BITS = thdt_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  dot0_seen;
  logic [COORD_BITS-1:0] dot0_x;
  logic [COORD_BITS-1:0] dot0_y;
  logic                  dot1_seen;
  logic [COORD_BITS-1:0] dot1_x;
  logic [COORD_BITS-1:0] dot1_y;
  logic                  dot2_seen;
  logic [COORD_BITS-1:0] dot2_x;
  logic [COORD_BITS-1:0] dot2_y;
  logic                  dot3_seen;
  logic [COORD_BITS-1:0] dot3_x;
  logic [COORD_BITS-1:0] dot3_y;

  modport source (
    output valid, dot0_seen, dot0_x, dot0_y, dot1_seen, dot1_x, dot1_y,
           dot2_seen, dot2_x, dot2_y, dot3_seen, dot3_x, dot3_y,
    input  ready
  );

  modport sink (
    input  valid, dot0_seen, dot0_x, dot0_y, dot1_seen, dot1_x, dot1_y,
           dot2_seen, dot2_x, dot2_y, dot3_seen, dot3_x, dot3_y,
    output ready
  );
endinterface

// ----- src/thdt_result_if.sv -----
// Interface: tracked hand result with valid/ready handshake.
interface thdt_result_if #(
  parameter int COORD_BITS = thdt_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            left_quadrant;
  logic [1:0]            right_quadrant;
  logic [COORD_BITS-1:0] left_pos_x;
  logic [COORD_BITS-1:0] left_pos_y;
  logic [COORD_BITS-1:0] right_pos_x;
  logic [COORD_BITS-1:0] right_pos_y;
  logic                  left_updated;
  logic                  right_updated;

  modport source (
    output valid, left_quadrant, right_quadrant, left_pos_x, left_pos_y,
           right_pos_x, right_pos_y, left_updated, right_updated,
    input  ready
  );

  modport sink (
    input  valid, left_quadrant, right_quadrant, left_pos_x, left_pos_y,
           right_pos_x, right_pos_y, left_updated, right_updated,
    output ready
  );
endinterface

// ----- src/two_hand_ir_dot_tracker.sv -----
// Top level: two-hand IR dot tracker, frame register, match logic and result register.
//
// Takes one frame of four IR dots per transfer and reports both tracked hand
// positions and quadrants after that frame. One frame transfer is taken every
// clock cycle while the result side does not stall; a result passes from its
// frame transfer through the frame register and then the result register,
// which takes it once it is free. The match logic between the two registers
// reads and writes the stored hand state in the same cycle, so consecutive
// frames need no spacing. The result register decouples the sides: a new frame
// is taken while a finished result waits, up to one frame in the frame
// register. Writing a start position register also presets the stored hand
// position at once. Unknown register indexes are ignored.
module two_hand_ir_dot_tracker #(
  parameter int COORD_BITS = thdt_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  thdt_frame_if.sink                           frame,
  thdt_result_if.source                        result,
  input  logic                                 cfg_we,
  input  logic [thdt_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [COORD_BITS:0]                  cfg_data
);
  import thdt_pkg::*;

  localparam int RAD_BITS = COORD_BITS + 1;
  localparam int SCALE    = 1 << COORD_BITS;
  localparam logic [RAD_BITS-1:0]   CHANGE_RST = RAD_BITS'((SCALE * 2 + 5) / 10);
  localparam logic [RAD_BITS-1:0]   MERGE_RST  = RAD_BITS'((SCALE + 5) / 10);
  localparam logic [COORD_BITS-1:0] LX_RST = COORD_BITS'((SCALE * 80 + 50) / 100);
  localparam logic [COORD_BITS-1:0] LY_RST = COORD_BITS'((SCALE * 61 + 50) / 100);
  localparam logic [COORD_BITS-1:0] RX_RST = COORD_BITS'((SCALE * 53 + 50) / 100);
  localparam logic [COORD_BITS-1:0] RY_RST = COORD_BITS'((SCALE * 63 + 50) / 100);
  localparam logic [COORD_BITS-1:0] HALF   = COORD_BITS'(1) << (COORD_BITS - 1);

  // configuration
  logic [RAD_BITS-1:0]   change_radius;
  logic [RAD_BITS-1:0]   merge_radius;

  // hand state
  logic [COORD_BITS-1:0] left_x, left_y, right_x, right_y;
  logic [1:0]            left_quad, right_quad;

  // frame register
  logic                  s1_valid;
  logic                  dot_seen [NUM_DOTS];
  logic [COORD_BITS-1:0] dot_x    [NUM_DOTS];
  logic [COORD_BITS-1:0] dot_y    [NUM_DOTS];

  // result register
  logic                  out_valid;

  logic                  out_free;
  logic                  advance;

  // match logic
  logic                  any_seen;
  logic [1:0]            imin, imax;
  logic [COORD_BITS-1:0] max_x, max_y, min_x, min_y;
  logic [COORD_BITS-1:0] ad0, ad1, ad2, ad3, ad4, ad5;
  logic [RAD_BITS-1:0]   dist_l, dist_r, dist_sep;
  logic                  single_dot, merged;
  logic                  lu, ru;
  logic [1:0]            max_quad, min_quad;

  logic [COORD_BITS-1:0] left_x_next, left_y_next, right_x_next, right_y_next;
  logic [1:0]            left_quad_next, right_quad_next;

  function automatic logic [COORD_BITS-1:0] absdiff(
    input logic [COORD_BITS-1:0] a,
    input logic [COORD_BITS-1:0] b
  );
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [1:0] quad_of(
    input logic [COORD_BITS-1:0] x,
    input logic [COORD_BITS-1:0] y
  );
    logic row, col;
    row = !(y > HALF);
    col = !(x < HALF);
    return {row, col};
  endfunction

  assign out_free    = !out_valid || result.ready;
  assign advance     = s1_valid && out_free;
  assign frame.ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (frame.ready) begin
      s1_valid <= frame.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.valid && frame.ready) begin
      dot_seen[0] <= frame.dot0_seen;
      dot_x[0]    <= frame.dot0_x;
      dot_y[0]    <= frame.dot0_y;
      dot_seen[1] <= frame.dot1_seen;
      dot_x[1]    <= frame.dot1_x;
      dot_y[1]    <= frame.dot1_y;
      dot_seen[2] <= frame.dot2_seen;
      dot_x[2]    <= frame.dot2_x;
      dot_y[2]    <= frame.dot2_y;
      dot_seen[3] <= frame.dot3_seen;
      dot_x[3]    <= frame.dot3_x;
      dot_y[3]    <= frame.dot3_y;
    end
  end

  // min/max X over seen dots; lowest index wins ties
  always_comb begin
    any_seen = 1'b0;
    imin     = 2'd0;
    imax     = 2'd0;
    for (int i = 0; i < NUM_DOTS; i++) begin
      if (dot_seen[i]) begin
        if (!any_seen) begin
          any_seen = 1'b1;
          imin     = 2'(i);
          imax     = 2'(i);
        end else begin
          if (dot_x[i] < dot_x[imin]) begin
            imin = 2'(i);
          end
          if (dot_x[i] > dot_x[imax]) begin
            imax = 2'(i);
          end
        end
      end
    end
  end

  assign max_x = dot_x[imax];
  assign max_y = dot_y[imax];
  assign min_x = dot_x[imin];
  assign min_y = dot_y[imin];

  assign ad0 = absdiff(left_x, max_x);
  assign ad1 = absdiff(left_y, max_y);
  assign ad2 = absdiff(right_x, min_x);
  assign ad3 = absdiff(right_y, min_y);
  assign ad4 = absdiff(max_x, min_x);
  assign ad5 = absdiff(max_y, min_y);

  assign dist_l   = {1'b0, ad0} + {1'b0, ad1};
  assign dist_r   = {1'b0, ad2} + {1'b0, ad3};
  assign dist_sep = {1'b0, ad4} + {1'b0, ad5};

  assign single_dot = (imin == imax);
  assign merged     = !single_dot && (dist_sep < merge_radius);
  assign max_quad   = quad_of(max_x, max_y);
  assign min_quad   = quad_of(min_x, min_y);

  always_comb begin
    lu = 1'b0;
    ru = 1'b0;
    if (any_seen) begin
      if (single_dot || merged) begin
        lu = (dist_l < dist_r);
        ru = !(dist_l < dist_r);
      end else begin
        lu = (dist_l < change_radius);
        ru = (dist_r < change_radius);
      end
    end
    left_x_next     = lu ? max_x    : left_x;
    left_y_next     = lu ? max_y    : left_y;
    left_quad_next  = lu ? max_quad : left_quad;
    right_x_next    = ru ? min_x    : right_x;
    right_y_next    = ru ? min_y    : right_y;
    right_quad_next = ru ? min_quad : right_quad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      change_radius <= CHANGE_RST;
      merge_radius  <= MERGE_RST;
      left_x        <= LX_RST;
      left_y        <= LY_RST;
      right_x       <= RX_RST;
      right_y       <= RY_RST;
      left_quad     <= 2'd0;
      right_quad    <= 2'd0;
    end else begin
      if (advance) begin
        left_x     <= left_x_next;
        left_y     <= left_y_next;
        right_x    <= right_x_next;
        right_y    <= right_y_next;
        left_quad  <= left_quad_next;
        right_quad <= right_quad_next;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_CHANGE_RADIUS: change_radius <= cfg_data;
          REG_MERGE_RADIUS:  merge_radius  <= cfg_data;
          REG_LEFT_START_X:  left_x        <= cfg_data[COORD_BITS-1:0];
          REG_LEFT_START_Y:  left_y        <= cfg_data[COORD_BITS-1:0];
          REG_RIGHT_START_X: right_x       <= cfg_data[COORD_BITS-1:0];
          REG_RIGHT_START_Y: right_y       <= cfg_data[COORD_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.left_quadrant  <= left_quad_next;
      result.right_quadrant <= right_quad_next;
      result.left_pos_x     <= left_x_next;
      result.left_pos_y     <= left_y_next;
      result.right_pos_x    <= right_x_next;
      result.right_pos_y    <= right_y_next;
      result.left_updated   <= lu;
      result.right_updated  <= ru;
    end
  end

  assign result.valid = out_valid;

endmodule
